### rtl/enp_pkg.sv
`timescale 1ns / 1ps

package enp_pkg;

    // field widths
    localparam int COORD_W    = 32;
    localparam int AXIS_W     = 16;
    localparam int SCALE_W    = 16;
    localparam int IDX_W      = 16;
    localparam int DIST_W     = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // shared multiplier and datapath widths
    localparam int MUL_W  = 32;
    localparam int PROD_W = 2 * MUL_W;
    localparam int LEN_W  = 64;          // Q32.32 distance squared
    localparam int A_W    = 51;          // signed dot product, Q.30
    localparam int AM_W   = 36;          // |a| truncated to Q20.16
    localparam int Q_W    = 2 * AM_W;    // a squared
    localparam int P_W    = Q_W + MUL_W; // f * a squared, Q.48
    localparam int REM_W  = 35;          // square root remainder

    // set bookkeeping
    localparam int MAX_POINTS = 65536;
    localparam int CNT_W      = 17;

    // sequencing
    localparam int SQRT_STEPS = DIST_W;
    localparam int STEP_W     = 4;
    localparam logic [STEP_W-1:0] CALC_LAST = 4'd14;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_AXIS_X   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_AXIS_Y   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_AXIS_Z   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_SCALE    = 3'd6;

    localparam logic [AXIS_W-1:0]  AXIS_Z_RESET = 16'd16384;
    localparam logic [SCALE_W-1:0] SCALE_RESET  = 16'd256;
    localparam logic [MUL_W-1:0]   SCALE_ONE_SQ = 32'd65536;

    // datapath operations
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NONE = 4'd0;
    localparam logic [OP_W-1:0] OP_AX   = 4'd1;   // axis component times |v|
    localparam logic [OP_W-1:0] OP_ABS  = 4'd2;   // |a| >> 14
    localparam logic [OP_W-1:0] OP_SQ   = 4'd3;   // |v| component squared
    localparam logic [OP_W-1:0] OP_Q0   = 4'd4;   // a squared, low x low
    localparam logic [OP_W-1:0] OP_Q1   = 4'd5;   // a squared, cross term
    localparam logic [OP_W-1:0] OP_Q2   = 4'd6;   // a squared, high x high
    localparam logic [OP_W-1:0] OP_SS   = 4'd7;   // scale squared minus one
    localparam logic [OP_W-1:0] OP_P0   = 4'd8;   // f times a squared, word 0
    localparam logic [OP_W-1:0] OP_P1   = 4'd9;
    localparam logic [OP_W-1:0] OP_P2   = 4'd10;
    localparam logic [OP_W-1:0] OP_CMP  = 4'd11;  // form r2, update minimum
    localparam logic [OP_W-1:0] OP_FIN  = 4'd12;  // close the set
    localparam logic [OP_W-1:0] OP_ROOT = 4'd13;  // one square root digit
    localparam logic [OP_W-1:0] OP_PUT  = 4'd14;  // load output register

    typedef struct packed {
        logic            load;   // input word accepted this cycle
        logic [OP_W-1:0] op;
        logic [1:0]      sel;    // coordinate select
    } t_cmd;

    typedef struct packed {
        logic out_free;          // output register can take a result
    } t_status;

    // per-point schedule on the shared multiplier; each operation's result
    // is folded in the cycle after issue, so f is ready well before word 0 of f * a^2
    function automatic t_cmd calc_cmd(input logic [STEP_W-1:0] step);
        t_cmd c;
        c.load = 1'b0;
        c.op   = OP_NONE;
        c.sel  = 2'd0;
        case (step)
            4'd0: begin
                c.op = OP_AX;
                c.sel = 2'd0;
            end
            4'd1: begin
                c.op = OP_AX;
                c.sel = 2'd1;
            end
            4'd2: begin
                c.op = OP_AX;
                c.sel = 2'd2;
            end
            4'd3: c.op = OP_ABS;
            4'd4: c.op = OP_SS;
            4'd5: c.op = OP_Q0;
            4'd6: c.op = OP_Q1;
            4'd7: c.op = OP_Q2;
            4'd8: begin
                c.op = OP_SQ;
                c.sel = 2'd0;
            end
            4'd9: c.op = OP_P0;
            4'd10: c.op = OP_P1;
            4'd11: c.op = OP_P2;
            4'd12: begin
                c.op = OP_SQ;
                c.sel = 2'd1;
            end
            4'd13: begin
                c.op = OP_SQ;
                c.sel = 2'd2;
            end
            4'd14: c.op = OP_CMP;
            default: c.op = OP_NONE;
        endcase
        return c;
    endfunction

endpackage

### rtl/enp_ctrl.sv
`timescale 1ns / 1ps

module enp_ctrl import enp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_has_point,
    input  logic    i_last,
    input  t_status i_sts,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CALC = 3'd1;
    localparam logic [2:0] S_FIN  = 3'd2;
    localparam logic [2:0] S_ROOT = 3'd3;
    localparam logic [2:0] S_PUT  = 3'd4;

    localparam int RCNT_W = $clog2(SQRT_STEPS);
    localparam logic [RCNT_W-1:0] RCNT_LAST = RCNT_W'(SQRT_STEPS - 1);

    logic [2:0]        r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic [RCNT_W-1:0] r_rcnt, n_rcnt;
    logic              r_last, n_last;
    logic              accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid & o_in_ready;

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_rcnt     = r_rcnt;
        n_last     = r_last;
        o_cmd.load = accept;
        o_cmd.op   = OP_NONE;
        o_cmd.sel  = 2'd0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_last = i_last;
                    n_step = '0;
                    if (i_has_point) begin
                        n_state = S_CALC;
                    end else if (i_last) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_CALC: begin
                o_cmd.op  = calc_cmd(r_step).op;
                o_cmd.sel = calc_cmd(r_step).sel;
                if (r_step == CALC_LAST) begin
                    n_state = r_last ? S_FIN : S_IDLE;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_FIN: begin
                o_cmd.op = OP_FIN;
                n_rcnt   = '0;
                n_state  = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.op = OP_ROOT;
                if (r_rcnt == RCNT_LAST) begin
                    n_state = S_PUT;
                end else begin
                    n_rcnt = r_rcnt + 1'b1;
                end
            end
            S_PUT: begin
                // wait for the output register to drain
                if (i_sts.out_free) begin
                    o_cmd.op = OP_PUT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_rcnt  <= '0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_rcnt  <= n_rcnt;
            r_last  <= n_last;
        end
    end

`ifndef SYNTH
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CALC) |-> (r_step <= CALC_LAST))
        else $error("schedule step past end");

    a_point_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_has_point) |=> (r_state == S_CALC && r_step == '0))
        else $error("point word did not start the schedule");

    a_root_put: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROOT && r_rcnt == RCNT_LAST) |=> (r_state == S_PUT))
        else $error("square root did not hand over to output");
`endif

endmodule

### rtl/enp_datapath.sv
`timescale 1ns / 1ps

module enp_datapath import enp_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_cmd                         i_cmd,
    input  logic signed [COORD_W-1:0]    i_point_x,
    input  logic signed [COORD_W-1:0]    i_point_y,
    input  logic signed [COORD_W-1:0]    i_point_z,
    input  logic                         i_cfg_we,
    input  logic        [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic        [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                         i_out_ready,
    output t_status                      o_sts,
    output logic                         o_out_valid,
    output logic        [IDX_W-1:0]      o_nearest_index,
    output logic        [DIST_W-1:0]     o_distance,
    output logic                         o_found
);

    // configuration
    logic [COORD_W-1:0] r_origin [3];
    logic [AXIS_W-1:0]  r_axis [3];
    logic [SCALE_W-1:0] r_scale;

    // point offset, magnitude and sign per coordinate
    logic [COORD_W-1:0] point [3];
    logic [COORD_W:0]   diff [3];
    logic [COORD_W:0]   dmag [3];
    logic [COORD_W-1:0] r_vm [3];
    logic               r_vs [3];

    // multiplier stage
    logic [AXIS_W-1:0] axis_sel;
    logic [AXIS_W-1:0] axis_mag;
    logic [MUL_W-1:0]  mul_a, mul_b;
    logic [PROD_W-1:0] r_prod;
    logic [OP_W-1:0]   r_op_d;
    logic [1:0]        r_sel_d;
    logic              r_neg_d;

    // accumulators
    logic [A_W-1:0]   r_a;
    logic [AM_W-1:0]  r_am;
    logic [LEN_W-1:0] r_len2;
    logic [Q_W-1:0]   r_q;
    logic [MUL_W-1:0] r_f;
    logic [P_W-1:0]   r_p;

    // search state
    logic [LEN_W-1:0] r_best;
    logic [IDX_W-1:0] r_best_idx;
    logic [CNT_W-1:0] r_count;
    logic             r_any;

    // square root
    logic [LEN_W-1:0]  r_sx;
    logic [REM_W-1:0]  r_rem;
    logic [DIST_W-1:0] r_root;
    logic [IDX_W-1:0]  r_res_idx;
    logic              r_res_found;

    // output register
    logic              r_out_valid;
    logic [IDX_W-1:0]  r_out_idx;
    logic [DIST_W-1:0] r_out_dist;
    logic              r_out_found;

    // combinational helpers
    logic [A_W-1:0]    ax_pos, ax_term, a_mag;
    logic [LEN_W:0]    len_sum, r2_sum;
    logic [LEN_W-1:0]  len_sat, term, r2;
    logic [MUL_W-1:0]  ss_f;
    logic [REM_W-1:0]  root_t, root_trial;
    logic              root_ge;

    assign point[0] = i_point_x;
    assign point[1] = i_point_y;
    assign point[2] = i_point_z;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin[0] <= '0;
            r_origin[1] <= '0;
            r_origin[2] <= '0;
            r_axis[0]   <= '0;
            r_axis[1]   <= '0;
            r_axis[2]   <= AXIS_Z_RESET;
            r_scale     <= SCALE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_ORIGIN_X: r_origin[0] <= i_cfg_data[COORD_W-1:0];
                REG_ORIGIN_Y: r_origin[1] <= i_cfg_data[COORD_W-1:0];
                REG_ORIGIN_Z: r_origin[2] <= i_cfg_data[COORD_W-1:0];
                REG_AXIS_X:   r_axis[0]   <= i_cfg_data[AXIS_W-1:0];
                REG_AXIS_Y:   r_axis[1]   <= i_cfg_data[AXIS_W-1:0];
                REG_AXIS_Z:   r_axis[2]   <= i_cfg_data[AXIS_W-1:0];
                REG_SCALE:    r_scale     <= i_cfg_data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // v = point - origin, exact in 33 bits, kept as sign and magnitude
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            diff[i] = {point[i][COORD_W-1], point[i]}
                    - {r_origin[i][COORD_W-1], r_origin[i]};
            dmag[i] = diff[i][COORD_W] ? (~diff[i] + 1'b1) : diff[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int i = 0; i < 3; i++) begin
                r_vm[i] <= dmag[i][COORD_W-1:0];
                r_vs[i] <= diff[i][COORD_W];
            end
        end
    end

    // operand select for the shared multiplier
    assign axis_sel = r_axis[i_cmd.sel];
    assign axis_mag = axis_sel[AXIS_W-1] ? (~axis_sel + 1'b1) : axis_sel;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            OP_AX: begin
                mul_a = MUL_W'(axis_mag);
                mul_b = r_vm[i_cmd.sel];
            end
            OP_SQ: begin
                mul_a = r_vm[i_cmd.sel];
                mul_b = r_vm[i_cmd.sel];
            end
            OP_Q0: begin
                mul_a = r_am[MUL_W-1:0];
                mul_b = r_am[MUL_W-1:0];
            end
            OP_Q1: begin
                mul_a = MUL_W'(r_am[AM_W-1:MUL_W]);
                mul_b = r_am[MUL_W-1:0];
            end
            OP_Q2: begin
                mul_a = MUL_W'(r_am[AM_W-1:MUL_W]);
                mul_b = MUL_W'(r_am[AM_W-1:MUL_W]);
            end
            OP_SS: begin
                mul_a = MUL_W'(r_scale);
                mul_b = MUL_W'(r_scale);
            end
            OP_P0: begin
                mul_a = r_q[MUL_W-1:0];
                mul_b = r_f;
            end
            OP_P1: begin
                mul_a = r_q[2*MUL_W-1:MUL_W];
                mul_b = r_f;
            end
            OP_P2: begin
                mul_a = MUL_W'(r_q[Q_W-1:2*MUL_W]);
                mul_b = r_f;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod  <= PROD_W'(mul_a) * PROD_W'(mul_b);
        r_sel_d <= i_cmd.sel;
        r_neg_d <= axis_sel[AXIS_W-1] ^ r_vs[i_cmd.sel];
    end

    // fold-in arithmetic
    assign ax_pos  = A_W'(r_prod[AXIS_W+COORD_W-1:0]);
    assign ax_term = r_neg_d ? (~ax_pos + 1'b1) : ax_pos;
    assign a_mag   = r_a[A_W-1] ? (~r_a + 1'b1) : r_a;

    assign len_sum = {1'b0, r_len2} + {1'b0, r_prod};
    assign len_sat = len_sum[LEN_W] ? '1 : len_sum[LEN_W-1:0];

    assign ss_f = (r_prod[MUL_W-1:0] > SCALE_ONE_SQ) ? (r_prod[MUL_W-1:0] - SCALE_ONE_SQ) : '0;

    // f * a^2 is Q.48: drop 16 fraction bits, saturate above 64 bits
    assign term   = (|r_p[P_W-1:LEN_W+16]) ? '1 : r_p[LEN_W+15:16];
    assign r2_sum = {1'b0, r_len2} + {1'b0, term};
    assign r2     = r2_sum[LEN_W] ? '1 : r2_sum[LEN_W-1:0];

    // restoring square root, one result bit per step
    assign root_t     = {r_rem[REM_W-3:0], r_sx[LEN_W-1:LEN_W-2]};
    assign root_trial = {1'b0, r_root, 2'b01};
    assign root_ge    = (root_t >= root_trial);

    // payload side of each operation
    always_ff @(posedge i_clk) begin
        case (r_op_d)
            OP_AX:  r_a <= (r_sel_d == '0) ? ax_term : (r_a + ax_term);
            OP_ABS: r_am <= a_mag[AM_W+13:14];
            OP_SQ:  r_len2 <= (r_sel_d == '0) ? r_prod : len_sat;
            OP_Q0:  r_q <= Q_W'(r_prod);
            OP_Q1:  r_q <= r_q + {r_prod[Q_W-34:0], 33'd0};
            OP_Q2:  r_q <= r_q + {r_prod[Q_W-2*MUL_W-1:0], 64'd0};
            OP_SS:  r_f <= ss_f;
            OP_P0:  r_p <= P_W'(r_prod);
            OP_P1:  r_p <= r_p + {8'd0, r_prod, 32'd0};
            OP_P2:  r_p <= r_p + {r_prod[P_W-2*MUL_W-1:0], 64'd0};
            OP_FIN: begin
                r_sx        <= r_best;
                r_res_idx   <= r_best_idx;
                r_res_found <= r_any;
                r_rem       <= '0;
                r_root      <= '0;
            end
            OP_ROOT: begin
                r_rem  <= root_ge ? (root_t - root_trial) : root_t;
                r_root <= {r_root[DIST_W-2:0], root_ge};
                r_sx   <= {r_sx[LEN_W-3:0], 2'b00};
            end
            OP_PUT: begin
                r_out_idx   <= r_res_idx;
                r_out_dist  <= r_res_found ? r_root : '1;
                r_out_found <= r_res_found;
            end
            default: ;
        endcase
    end

    // search state, operation pipe and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_d      <= OP_NONE;
            r_best      <= '1;
            r_best_idx  <= '0;
            r_count     <= '0;
            r_any       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_op_d <= i_cmd.op;
            if (r_op_d == OP_CMP) begin
                // points past the set limit are dropped
                if (r_count < CNT_W'(MAX_POINTS)) begin
                    if (!r_any || (r2 < r_best)) begin
                        r_best     <= r2;
                        r_best_idx <= r_count[IDX_W-1:0];
                    end
                    r_any   <= 1'b1;
                    r_count <= r_count + 1'b1;
                end
            end else if (r_op_d == OP_FIN) begin
                r_best     <= '1;
                r_best_idx <= '0;
                r_count    <= '0;
                r_any      <= 1'b0;
            end
            if (r_op_d == OP_PUT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.out_free   = !r_out_valid || i_out_ready;
    assign o_out_valid      = r_out_valid;
    assign o_nearest_index  = r_out_idx;
    assign o_distance       = r_out_dist;
    assign o_found          = r_out_found;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_POINTS))
        else $error("point count past set limit");

    a_empty_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_any |-> (r_best == '1 && r_best_idx == '0 && r_count == '0))
        else $error("search state not clear while set is empty");

    a_empty_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_found) |-> (r_out_dist == '1 && r_out_idx == '0))
        else $error("empty set result not all ones");
`endif

endmodule

### rtl/elliptical_nearest_point.sv
`timescale 1ns / 1ps
// Point word: no new word is taken until the 15-step schedule on the single shared
// 32x32 multiplier is done. A word with no point and no last flag leaves the
// sequencer idle and ready. Last word: the 32-step bit-serial square root dominates
// the time to a result. Result sits in an output register.
// Reset: synchronous, active low; registers return to their reset values and the
// search state is cleared.

module elliptical_nearest_point import enp_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [COORD_W-1:0]    i_point_x,
    input  logic signed [COORD_W-1:0]    i_point_y,
    input  logic signed [COORD_W-1:0]    i_point_z,
    input  logic                         i_has_point,
    input  logic                         i_last,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic        [IDX_W-1:0]      o_nearest_index,
    output logic        [DIST_W-1:0]     o_distance,
    output logic                         o_found,
    input  logic                         i_cfg_we,
    input  logic        [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic        [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd    cmd;
    t_status sts;

    // sequencer
    enp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_has_point (i_has_point),
        .i_last      (i_last),
        .i_sts       (sts),
        .o_in_ready  (o_in_ready),
        .o_cmd       (cmd)
    );

    // arithmetic, search state and output register
    enp_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_point_x       (i_point_x),
        .i_point_y       (i_point_y),
        .i_point_z       (i_point_z),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data),
        .i_out_ready     (i_out_ready),
        .o_sts           (sts),
        .o_out_valid     (o_out_valid),
        .o_nearest_index (o_nearest_index),
        .o_distance      (o_distance),
        .o_found         (o_found)
    );

endmodule
